/* design/rht_pkg.sv */
// ----------------------------------------------------------------------------
// rht_pkg
// Shared constants for the reference-counted handle table: sizes, command
// codes and result status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package rht_pkg;

    // table geometry
    localparam int MAX_ENTRIES = 64;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    // field widths
    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int REF_W = 16;
    localparam int CMD_W = 2;
    localparam int ST_W  = 3;

    // command codes
    localparam logic [CMD_W-1:0] CMD_CREATE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP  = 2'd2;

    // status codes
    localparam logic [ST_W-1:0] ST_ADDED       = 3'd0;
    localparam logic [ST_W-1:0] ST_REF_ADDED   = 3'd1;
    localparam logic [ST_W-1:0] ST_DECREMENTED = 3'd2;
    localparam logic [ST_W-1:0] ST_REMOVED     = 3'd3;
    localparam logic [ST_W-1:0] ST_FOUND       = 3'd4;
    localparam logic [ST_W-1:0] ST_NOT_FOUND   = 3'd5;
    localparam logic [ST_W-1:0] ST_FULL        = 3'd6;
    localparam logic [ST_W-1:0] ST_DISABLED    = 3'd7;

    // reference count limit
    localparam logic [REF_W-1:0] REF_MAX = '1;

endpackage

`default_nettype wire

/* design/refcounted_handle_table.sv */
// An enabled request scans the key store one entry per cycle through the RAM
// read port; a disabled request skips the scan and goes straight to the response
// state. A hit moves on through the fetch and update states, and a release that
// drops the last reference also through the move-read and move-write states. One
// request at a time; the next is taken once the result is registered. Reset
// clears the entry count, the enable bit and the handshake state; the key, value
// and count stores are not cleared.
// ----------------------------------------------------------------------------
// refcounted_handle_table
// Packed key/value table with reference counts, linear search, append on
// create and move-last-into-slot on removal.
// ----------------------------------------------------------------------------
`default_nettype none

module refcounted_handle_table
    import rht_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration write channel: table_enabled
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data,
    // request channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // [31:0] key, [63:32] new_value
    input  wire logic [1:0]  s_tuser,   // [1:0] cmd
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [31:0] found_value, [38:32] entry_count
    output logic [2:0]       m_tuser    // [2:0] status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_FETCH,
        S_UPDATE,
        S_MOVE_RD,
        S_MOVE_WR,
        S_RESP
    } state_t;

    state_t            state_reg;
    logic [CMD_W-1:0]  cmd_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [VAL_W-1:0]  nval_reg;
    logic [CNT_W-1:0]  scan_reg;
    logic              cmp_pend_reg;
    logic [IDX_W-1:0]  cmp_idx_reg;
    logic [IDX_W-1:0]  slot_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              enabled_reg;
    logic [ST_W-1:0]   res_status_reg;
    logic [VAL_W-1:0]  res_value_reg;
    logic              m_tvalid_reg;
    logic [ST_W-1:0]   m_status_reg;
    logic [VAL_W-1:0]  m_value_reg;
    logic [CNT_W-1:0]  m_count_reg;

    // ram ports
    logic [IDX_W-1:0]  rd_addr;
    logic [IDX_W-1:0]  wr_addr;
    logic              key_we;
    logic              val_we;
    logic              ref_we;
    logic [KEY_W-1:0]  key_wdata;
    logic [VAL_W-1:0]  val_wdata;
    logic [REF_W-1:0]  ref_wdata;
    logic [KEY_W-1:0]  key_rdata;
    logic [VAL_W-1:0]  val_rdata;
    logic [REF_W-1:0]  ref_rdata;

    logic              key_match;
    logic              scan_done;
    logic              has_room;
    logic              append_go;
    logic [IDX_W-1:0]  last_idx;

    // configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enabled_reg <= 1'b0;
        end else if (cfg_valid) begin
            enabled_reg <= cfg_data;
        end
    end

    // search compare and append decision
    assign key_match = cmp_pend_reg && (key_rdata == key_reg);
    assign scan_done = (scan_reg >= count_reg);
    assign has_room  = (count_reg < CNT_W'(MAX_ENTRIES));
    assign append_go = (state_reg == S_SEARCH) && !key_match && scan_done
                       && (cmd_reg == CMD_CREATE) && has_room;
    assign last_idx  = IDX_W'(count_reg - 1'b1);

    // ram read address
    always_comb begin
        case (state_reg)
            S_SEARCH:  rd_addr = scan_reg[IDX_W-1:0];
            S_MOVE_RD: rd_addr = last_idx;
            default:   rd_addr = slot_reg;
        endcase
    end

    // ram writes: append, count update, move of the last entry
    always_comb begin
        wr_addr   = slot_reg;
        key_we    = 1'b0;
        val_we    = 1'b0;
        ref_we    = 1'b0;
        key_wdata = key_rdata;
        val_wdata = val_rdata;
        ref_wdata = ref_rdata;
        if (append_go) begin
            wr_addr   = count_reg[IDX_W-1:0];
            key_we    = 1'b1;
            val_we    = 1'b1;
            ref_we    = 1'b1;
            key_wdata = key_reg;
            val_wdata = nval_reg;
            ref_wdata = REF_W'(1);
        end else if (state_reg == S_UPDATE) begin
            if (cmd_reg == CMD_CREATE) begin
                ref_we    = 1'b1;
                ref_wdata = (ref_rdata == REF_MAX) ? ref_rdata : ref_rdata + 1'b1;
            end else if (cmd_reg == CMD_RELEASE && ref_rdata > REF_W'(1)) begin
                ref_we    = 1'b1;
                ref_wdata = ref_rdata - 1'b1;
            end
        end else if (state_reg == S_MOVE_WR) begin
            key_we = 1'b1;
            val_we = 1'b1;
            ref_we = 1'b1;
        end
    end

    rht_ram #(.WIDTH(KEY_W), .DEPTH(MAX_ENTRIES)) u_key_ram (
        .aclk  (aclk),
        .we    (key_we),
        .waddr (wr_addr),
        .wdata (key_wdata),
        .raddr (rd_addr),
        .rdata (key_rdata)
    );

    rht_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ENTRIES)) u_val_ram (
        .aclk  (aclk),
        .we    (val_we),
        .waddr (wr_addr),
        .wdata (val_wdata),
        .raddr (rd_addr),
        .rdata (val_rdata)
    );

    rht_ram #(.WIDTH(REF_W), .DEPTH(MAX_ENTRIES)) u_ref_ram (
        .aclk  (aclk),
        .we    (ref_we),
        .waddr (wr_addr),
        .wdata (ref_wdata),
        .raddr (rd_addr),
        .rdata (ref_rdata)
    );

    // sequencer and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            cmp_pend_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // the response state reloads the result itself
            if (m_tvalid_reg && m_tready && state_reg != S_RESP) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        cmd_reg       <= s_tuser;
                        key_reg       <= s_tdata[31:0];
                        nval_reg      <= s_tdata[63:32];
                        scan_reg      <= '0;
                        cmp_pend_reg  <= 1'b0;
                        res_value_reg <= '0;
                        if (!enabled_reg) begin
                            res_status_reg <= ST_DISABLED;
                            state_reg      <= S_RESP;
                        end else begin
                            state_reg <= S_SEARCH;
                        end
                    end
                end
                S_SEARCH: begin
                    cmp_pend_reg <= (scan_reg < count_reg);
                    cmp_idx_reg  <= scan_reg[IDX_W-1:0];
                    if (!scan_done) begin
                        scan_reg <= scan_reg + 1'b1;
                    end
                    if (key_match) begin
                        slot_reg <= cmp_idx_reg;
                        if (cmd_reg == CMD_CREATE || cmd_reg == CMD_RELEASE
                            || cmd_reg == CMD_LOOKUP) begin
                            state_reg <= S_FETCH;
                        end else begin
                            res_status_reg <= ST_NOT_FOUND;
                            state_reg      <= S_RESP;
                        end
                    end else if (scan_done) begin
                        state_reg <= S_RESP;
                        if (cmd_reg == CMD_CREATE) begin
                            if (has_room) begin
                                count_reg      <= count_reg + 1'b1;
                                res_status_reg <= ST_ADDED;
                            end else begin
                                res_status_reg <= ST_FULL;
                            end
                        end else begin
                            res_status_reg <= ST_NOT_FOUND;
                        end
                    end
                end
                S_FETCH: begin
                    state_reg <= S_UPDATE;
                end
                S_UPDATE: begin
                    state_reg <= S_RESP;
                    case (cmd_reg)
                        CMD_CREATE: res_status_reg <= ST_REF_ADDED;
                        CMD_RELEASE: begin
                            if (ref_rdata > REF_W'(1)) begin
                                res_status_reg <= ST_DECREMENTED;
                            end else begin
                                state_reg <= S_MOVE_RD;
                            end
                        end
                        CMD_LOOKUP: begin
                            res_status_reg <= ST_FOUND;
                            res_value_reg  <= val_rdata;
                        end
                        default: res_status_reg <= ST_NOT_FOUND;
                    endcase
                end
                S_MOVE_RD: begin
                    state_reg <= S_MOVE_WR;
                end
                S_MOVE_WR: begin
                    count_reg      <= count_reg - 1'b1;
                    res_status_reg <= ST_REMOVED;
                    state_reg      <= S_RESP;
                end
                S_RESP: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_status_reg <= res_status_reg;
                        m_value_reg  <= res_value_reg;
                        m_count_reg  <= count_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // ports
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {1'b0, 7'(m_count_reg), m_value_reg};

endmodule

`default_nettype wire

/* design/rht_ram.sv */
// ----------------------------------------------------------------------------
// rht_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                             aclk,
    input  wire logic                             we,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                 wdata,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic      [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* design/rht_checker.sv */
// ----------------------------------------------------------------------------
// rht_checker
// Port-level checks for the reference-counted handle table.
// ----------------------------------------------------------------------------
`default_nettype none

module rht_checker
    import rht_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata,
    input wire logic [2:0]  m_tuser
);

    // one request in flight: an accepted request closes the input
    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while previous one still in work");

    // entry count never exceeds the table size
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[38:32] <= 7'(MAX_ENTRIES)))
        else $error("entry count above table size");

    // value only reported on a lookup hit
    a_value_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != ST_FOUND) |-> (m_tdata[31:0] == '0))
        else $error("found value nonzero outside lookup hit");

    // full only when the table really is full
    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_FULL) |-> (m_tdata[38:32] == 7'(MAX_ENTRIES)))
        else $error("full status with room left");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind refcounted_handle_table rht_checker u_rht_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
